### rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with reset disable
`define PSA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// clocked property that also holds during reset
`define PSA_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

### rtl/core/psa_pkg.sv
// ---------------------------------------------------------------------------
// psa_pkg
// shared types and constants of the phong shading accumulator
// ---------------------------------------------------------------------------
package psa_pkg;

  localparam int MAX_SAMPLES = 256;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  localparam int CRD_W = 21;
  localparam int DIF_W = 22;
  localparam int UNI_W = 16;
  localparam int COL_W = 16;
  localparam int SUM_W = 24;
  localparam int SQ_W  = 44;
  localparam int LEN_W = 23;
  localparam int DOT_W = 36;
  localparam int REF_W = 18;
  localparam int WGT_W = 15;
  localparam int TOT_W = 27;
  localparam int MA_W  = 28;
  localparam int MB_W  = 23;
  localparam int MP_W  = MA_W + MB_W;
  localparam int DCNT_W = 5;

  localparam int IN_DATA_W  = 360;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 3;

  localparam int OFS_POS   = 0;
  localparam int OFS_NRM   = 63;
  localparam int OFS_VIEW  = 126;
  localparam int OFS_LIGHT = 189;
  localparam int OFS_KD    = 252;
  localparam int OFS_KS    = 300;
  localparam int OFS_SHIN  = 348;

  localparam logic [WGT_W-1:0]  ONE_Q14    = WGT_W'(16384);
  localparam logic [COL_W-1:0]  LIGHT_RST  = COL_W'(16384);
  localparam logic [SUM_W-1:0]  SUM_MAX    = '1;
  localparam logic [SQ_W-1:0]   SQRT_B0    = SQ_W'(1) << (SQ_W - 2);
  localparam logic [DCNT_W-1:0] NDIV_STEPS = DCNT_W'(15);
  localparam logic [DCNT_W-1:0] FDIV_STEPS = DCNT_W'(SUM_W);

  localparam logic [CFG_ADDR_W-1:0] REG_AMBIENT_RED   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_AMBIENT_GREEN = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_AMBIENT_BLUE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_RED     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_GREEN   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LIGHT_BLUE    = 3'd5;

  localparam logic [1:0] VEC_L    = 2'd0;
  localparam logic [1:0] VEC_V    = 2'd1;
  localparam logic [1:0] VEC_N    = 2'd2;
  localparam logic [1:0] SEL_DIFF = 2'd0;
  localparam logic [1:0] SEL_SPEC = 2'd1;
  localparam logic [1:0] IDX_LAST = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SQ, OP_SQRT_START, OP_SQRT_STEP, OP_NDIV_START,
    OP_DIV_STEP, OP_NORM_WB, OP_DOT_NL, OP_WD, OP_REFL, OP_DOT_VR,
    OP_POW_INIT, OP_POW_MUL, OP_POW_SQR, OP_ACC_D, OP_ACC_S, OP_AMB,
    OP_FDIV_START, OP_FDIV_WB, OP_LIT, OP_EMIT_SHADE, OP_EMIT_LIGHT
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_SQ, S_SQRT_START, S_SQRT, S_NDIV_START, S_NDIV,
    S_NORM_WB, S_DOT_NL, S_WD, S_WD_CHK, S_REFL, S_DOT_VR, S_POW_INIT,
    S_POW_CHK, S_POW_MUL, S_POW_SQR, S_ACC_D, S_ACC_S, S_CHK, S_AMB,
    S_FDIV_START, S_FDIV, S_FDIV_WB, S_LIT, S_EMIT, S_EMIT_LIGHT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] vec;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic div_busy;
    logic light;
    logic shadowed;
    logic last;
    logic wd_zero;
    logic e_zero;
    logic cnt_zero;
    logic out_full;
  } stat_t;

endpackage

### rtl/core/psa_ctrl.sv
// ---------------------------------------------------------------------------
// psa_ctrl
// sequencer that steps the shared datapath through one light sample
// ---------------------------------------------------------------------------
module psa_ctrl import psa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] vec_q, vec_d;
  logic [1:0] idx_q, idx_d;
  logic       idx_end;

  assign idx_end = (idx_q == IDX_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vec_q   <= VEC_L;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      vec_q   <= vec_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    vec_d   = vec_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
          vec_d   = VEC_L;
          idx_d   = '0;
        end
      end
      S_DECODE: begin
        if (stat_i.light) begin
          state_d = stat_i.last ? S_EMIT_LIGHT : S_IDLE;
        end else if (stat_i.shadowed) begin
          state_d = S_CHK;
        end else begin
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        if (idx_end) begin
          state_d = S_SQRT_START;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      S_SQRT_START: state_d = S_SQRT;
      S_SQRT: begin
        if (!stat_i.sqrt_busy) begin
          state_d = S_NDIV_START;
        end
      end
      S_NDIV_START: state_d = S_NDIV;
      S_NDIV: begin
        if (!stat_i.div_busy) begin
          state_d = S_NORM_WB;
        end
      end
      S_NORM_WB: begin
        if (!idx_end) begin
          idx_d   = idx_q + 2'd1;
          state_d = S_NDIV_START;
        end else if (vec_q == VEC_N) begin
          idx_d   = '0;
          state_d = S_DOT_NL;
        end else begin
          idx_d   = '0;
          vec_d   = vec_q + 2'd1;
          state_d = S_SQ;
        end
      end
      S_DOT_NL: begin
        if (idx_end) begin
          state_d = S_WD;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      S_WD:     state_d = S_WD_CHK;
      S_WD_CHK: state_d = stat_i.wd_zero ? S_ACC_D : S_REFL;
      S_REFL: begin
        if (idx_end) begin
          state_d = S_DOT_VR;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      S_DOT_VR: begin
        if (idx_end) begin
          state_d = S_POW_INIT;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      S_POW_INIT: state_d = S_POW_CHK;
      S_POW_CHK:  state_d = stat_i.e_zero ? S_ACC_D : S_POW_MUL;
      S_POW_MUL:  state_d = S_POW_SQR;
      S_POW_SQR:  state_d = S_POW_CHK;
      S_ACC_D: begin
        if (idx_end) begin
          state_d = S_ACC_S;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      S_ACC_S: begin
        if (idx_end) begin
          state_d = S_CHK;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      S_CHK: begin
        idx_d   = '0;
        state_d = stat_i.last ? S_AMB : S_IDLE;
      end
      S_AMB: begin
        if (idx_end) begin
          idx_d   = '0;
          vec_d   = SEL_DIFF;
          state_d = stat_i.cnt_zero ? S_LIT : S_FDIV_START;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      S_FDIV_START: state_d = S_FDIV;
      S_FDIV: begin
        if (!stat_i.div_busy) begin
          state_d = S_FDIV_WB;
        end
      end
      S_FDIV_WB: begin
        if (!idx_end) begin
          idx_d   = idx_q + 2'd1;
          state_d = S_FDIV_START;
        end else if (vec_q == SEL_SPEC) begin
          idx_d   = '0;
          state_d = S_LIT;
        end else begin
          idx_d   = '0;
          vec_d   = SEL_SPEC;
          state_d = S_FDIV_START;
        end
      end
      S_LIT: begin
        if (idx_end) begin
          state_d = S_EMIT;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      S_EMIT, S_EMIT_LIGHT: begin
        if (!stat_i.out_full) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.vec  = vec_q;
    cmd_o.idx  = idx_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.op   = in_valid_i ? OP_LOAD : OP_NONE;
      end
      S_SQ:           cmd_o.op = OP_SQ;
      S_SQRT_START:   cmd_o.op = OP_SQRT_START;
      S_SQRT:         cmd_o.op = OP_SQRT_STEP;
      S_NDIV_START:   cmd_o.op = OP_NDIV_START;
      S_NDIV, S_FDIV: cmd_o.op = OP_DIV_STEP;
      S_NORM_WB:      cmd_o.op = OP_NORM_WB;
      S_DOT_NL:       cmd_o.op = OP_DOT_NL;
      S_WD:           cmd_o.op = OP_WD;
      S_REFL:         cmd_o.op = OP_REFL;
      S_DOT_VR:       cmd_o.op = OP_DOT_VR;
      S_POW_INIT:     cmd_o.op = OP_POW_INIT;
      S_POW_MUL:      cmd_o.op = OP_POW_MUL;
      S_POW_SQR:      cmd_o.op = OP_POW_SQR;
      S_ACC_D:        cmd_o.op = OP_ACC_D;
      S_ACC_S:        cmd_o.op = OP_ACC_S;
      S_AMB:          cmd_o.op = OP_AMB;
      S_FDIV_START:   cmd_o.op = OP_FDIV_START;
      S_FDIV_WB:      cmd_o.op = OP_FDIV_WB;
      S_LIT:          cmd_o.op = OP_LIT;
      S_EMIT:         cmd_o.op = stat_i.out_full ? OP_NONE : OP_EMIT_SHADE;
      S_EMIT_LIGHT:   cmd_o.op = stat_i.out_full ? OP_NONE : OP_EMIT_LIGHT;
      default:        cmd_o.op = OP_NONE;
    endcase
  end

endmodule

### rtl/core/psa_datapath.sv
// ---------------------------------------------------------------------------
// psa_datapath
// operand registers, shared multiplier, square root and divider units,
// running sums and the output register
// ---------------------------------------------------------------------------
module psa_datapath import psa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [1:0]            in_user_i,
  input  logic                  in_last_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [COL_W-1:0]      cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output stat_t                 stat_o
);

  // configuration and accumulated state
  logic [COL_W-1:0] amb_q [3];
  logic [COL_W-1:0] lit_q [3];
  logic [SUM_W-1:0] dsum_q [3];
  logic [SUM_W-1:0] ssum_q [3];
  logic [CNT_W-1:0] count_q;
  logic             out_valid_q;

  // per sample payload
  logic signed [DIF_W-1:0] d_q [3][3];
  logic [3*COL_W-1:0]      kd_q, ks_q;
  logic [7:0]              shin_q;
  logic                    light_q, shadowed_q, last_q;
  logic signed [UNI_W-1:0] l_q [3];
  logic signed [UNI_W-1:0] v_q [3];
  logic signed [UNI_W-1:0] n_q [3];
  logic signed [REF_W-1:0] r_q [3];
  logic [SQ_W-1:0]         sq_q, sx_q, sr_q, sb_q;
  logic [LEN_W-1:0]        rem_q, dsor_q;
  logic [SUM_W-1:0]        dvd_q, quo_q;
  logic [DCNT_W-1:0]       dcnt_q;
  logic signed [DOT_W-1:0] s_q;
  logic [WGT_W-1:0]        wd_q, base_q, acc_q;
  logic [7:0]              e_q;
  logic [TOT_W-1:0]        tot_q [3];
  logic [OUT_DATA_W-1:0]   out_data_q;

  // combinational helpers
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MP_W-1:0]  prod, prod_neg, refl_t;
  logic signed [DIF_W-1:0] dsel;
  logic [DIF_W-1:0]        mag;
  logic [SQ_W:0]           trial;
  logic [LEN_W:0]          dtry;
  logic [WGT_W-1:0]        qc;
  logic signed [UNI_W-1:0] unit;
  logic [COL_W-1:0]        kd_c, ks_c;
  logic [COL_W-1:0]        lit_y;
  logic [SUM_W-1:0]        fsum;

  function automatic logic [WGT_W-1:0] clamp_dot(input logic signed [DOT_W-1:0] s);
    logic signed [DOT_W-1:0] t;
    t = s >>> 14;
    if (s <= 0) begin
      return '0;
    end else if (t > $signed(DOT_W'(ONE_Q14))) begin
      return ONE_Q14;
    end
    return t[WGT_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [COL_W-1:0] a);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W+1)'(a);
    return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
  endfunction

  assign dsel  = d_q[cmd_i.vec][cmd_i.idx];
  assign mag   = dsel[DIF_W-1] ? DIF_W'(-dsel) : dsel;
  assign kd_c  = kd_q[cmd_i.idx*COL_W +: COL_W];
  assign ks_c  = ks_q[cmd_i.idx*COL_W +: COL_W];
  assign trial = {1'b0, sr_q} + {1'b0, sb_q};
  assign dtry  = {rem_q, dvd_q[SUM_W-1]};
  assign fsum  = (cmd_i.vec == SEL_SPEC) ? ssum_q[cmd_i.idx] : dsum_q[cmd_i.idx];

  // normalized component, zero for a zero length vector
  always_comb begin
    if (sr_q == '0) begin
      qc = '0;
    end else if (quo_q > SUM_W'(ONE_Q14)) begin
      qc = ONE_Q14;
    end else begin
      qc = quo_q[WGT_W-1:0];
    end
    unit = dsel[DIF_W-1] ? -$signed(UNI_W'(qc)) : $signed(UNI_W'(qc));
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SQ: begin
        mul_a = MA_W'(dsel);
        mul_b = MB_W'(dsel);
      end
      OP_DOT_NL: begin
        mul_a = MA_W'(n_q[cmd_i.idx]);
        mul_b = MB_W'(l_q[cmd_i.idx]);
      end
      OP_REFL: begin
        mul_a = $signed(MA_W'({wd_q, 1'b0}));
        mul_b = MB_W'(n_q[cmd_i.idx]);
      end
      OP_DOT_VR: begin
        mul_a = MA_W'(v_q[cmd_i.idx]);
        mul_b = MB_W'(r_q[cmd_i.idx]);
      end
      OP_POW_MUL: begin
        mul_a = $signed(MA_W'(acc_q));
        mul_b = $signed(MB_W'(base_q));
      end
      OP_POW_SQR: begin
        mul_a = $signed(MA_W'(base_q));
        mul_b = $signed(MB_W'(base_q));
      end
      OP_ACC_D: begin
        mul_a = $signed(MA_W'(wd_q));
        mul_b = $signed(MB_W'(kd_c));
      end
      OP_ACC_S: begin
        mul_a = $signed(MA_W'(acc_q));
        mul_b = $signed(MB_W'(ks_c));
      end
      OP_AMB: begin
        mul_a = $signed(MA_W'(amb_q[cmd_i.idx]));
        mul_b = $signed(MB_W'(kd_c));
      end
      OP_LIT: begin
        mul_a = $signed(MA_W'(tot_q[cmd_i.idx]));
        mul_b = $signed(MB_W'(lit_q[cmd_i.idx]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_neg = -prod;
  // quotient by 2^14 truncated toward zero
  assign refl_t   = prod[MP_W-1] ? -(prod_neg >>> 14) : (prod >>> 14);
  assign lit_y    = (|prod[MP_W-1:30]) ? '1 : prod[29:14];

  // control and accumulated state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        amb_q[c]  <= '0;
        lit_q[c]  <= LIGHT_RST;
        dsum_q[c] <= '0;
        ssum_q[c] <= '0;
      end
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_AMBIENT_RED:   amb_q[0] <= cfg_data_i;
          REG_AMBIENT_GREEN: amb_q[1] <= cfg_data_i;
          REG_AMBIENT_BLUE:  amb_q[2] <= cfg_data_i;
          REG_LIGHT_RED:     lit_q[0] <= cfg_data_i;
          REG_LIGHT_GREEN:   lit_q[1] <= cfg_data_i;
          REG_LIGHT_BLUE:    lit_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          if (!in_user_i[1] && (count_q < CNT_W'(MAX_SAMPLES))) begin
            count_q <= count_q + CNT_W'(1);
          end
        end
        OP_ACC_D: dsum_q[cmd_i.idx] <= sat_add(dsum_q[cmd_i.idx], prod[29:14]);
        OP_ACC_S: ssum_q[cmd_i.idx] <= sat_add(ssum_q[cmd_i.idx], prod[29:14]);
        OP_EMIT_SHADE, OP_EMIT_LIGHT: begin
          out_valid_q <= 1'b1;
          count_q     <= '0;
          for (int c = 0; c < 3; c++) begin
            dsum_q[c] <= '0;
            ssum_q[c] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        for (int c = 0; c < 3; c++) begin
          d_q[VEC_L][c] <= DIF_W'($signed(in_data_i[OFS_LIGHT + c*CRD_W +: CRD_W]))
                         - DIF_W'($signed(in_data_i[OFS_POS + c*CRD_W +: CRD_W]));
          d_q[VEC_V][c] <= DIF_W'($signed(in_data_i[OFS_VIEW + c*CRD_W +: CRD_W]))
                         - DIF_W'($signed(in_data_i[OFS_POS + c*CRD_W +: CRD_W]));
          d_q[VEC_N][c] <= DIF_W'($signed(in_data_i[OFS_NRM + c*CRD_W +: CRD_W]));
        end
        kd_q       <= in_data_i[OFS_KD +: 3*COL_W];
        ks_q       <= in_data_i[OFS_KS +: 3*COL_W];
        shin_q     <= in_data_i[OFS_SHIN +: 8];
        shadowed_q <= in_user_i[0];
        light_q    <= in_user_i[1];
        last_q     <= in_last_i;
      end
      OP_SQ: sq_q <= ((cmd_i.idx == '0) ? '0 : sq_q) + prod[SQ_W-1:0];
      OP_SQRT_START: begin
        sx_q <= sq_q;
        sr_q <= '0;
        sb_q <= SQRT_B0;
      end
      OP_SQRT_STEP: begin
        if (sb_q != '0) begin
          if ({1'b0, sx_q} >= trial) begin
            sx_q <= sx_q - trial[SQ_W-1:0];
            sr_q <= (sr_q >> 1) + sb_q;
          end else begin
            sr_q <= sr_q >> 1;
          end
          sb_q <= sb_q >> 2;
        end
      end
      OP_NDIV_START: begin
        dsor_q <= sr_q[LEN_W-1:0];
        rem_q  <= LEN_W'(mag >> 1);
        dvd_q  <= {mag[0], (SUM_W-1)'(0)};
        quo_q  <= '0;
        dcnt_q <= NDIV_STEPS;
      end
      OP_FDIV_START: begin
        dsor_q <= LEN_W'(count_q);
        rem_q  <= '0;
        dvd_q  <= fsum;
        quo_q  <= '0;
        dcnt_q <= FDIV_STEPS;
      end
      OP_DIV_STEP: begin
        if (dcnt_q != '0) begin
          if (dtry >= {1'b0, dsor_q}) begin
            rem_q <= LEN_W'(dtry - {1'b0, dsor_q});
            quo_q <= {quo_q[SUM_W-2:0], 1'b1};
          end else begin
            rem_q <= dtry[LEN_W-1:0];
            quo_q <= {quo_q[SUM_W-2:0], 1'b0};
          end
          dvd_q  <= dvd_q << 1;
          dcnt_q <= dcnt_q - DCNT_W'(1);
        end
      end
      OP_NORM_WB: begin
        case (cmd_i.vec)
          VEC_L:   l_q[cmd_i.idx] <= unit;
          VEC_V:   v_q[cmd_i.idx] <= unit;
          default: n_q[cmd_i.idx] <= unit;
        endcase
      end
      OP_DOT_NL, OP_DOT_VR: begin
        s_q <= ((cmd_i.idx == '0) ? '0 : s_q) + $signed(prod[DOT_W-1:0]);
      end
      OP_WD: begin
        wd_q  <= clamp_dot(s_q);
        acc_q <= '0;
      end
      OP_REFL: begin
        r_q[cmd_i.idx] <= $signed(refl_t[REF_W-1:0]) - REF_W'(l_q[cmd_i.idx]);
      end
      OP_POW_INIT: begin
        base_q <= clamp_dot(s_q);
        acc_q  <= ONE_Q14;
        e_q    <= shin_q;
      end
      OP_POW_MUL: begin
        if (e_q[0]) begin
          acc_q <= prod[28:14];
        end
      end
      OP_POW_SQR: begin
        base_q <= prod[28:14];
        e_q    <= e_q >> 1;
      end
      OP_AMB:     tot_q[cmd_i.idx] <= TOT_W'(prod[31:14]);
      OP_FDIV_WB: tot_q[cmd_i.idx] <= tot_q[cmd_i.idx] + TOT_W'(quo_q);
      OP_LIT:     tot_q[cmd_i.idx] <= TOT_W'(lit_y);
      OP_EMIT_SHADE: begin
        out_data_q <= {tot_q[2][COL_W-1:0], tot_q[1][COL_W-1:0], tot_q[0][COL_W-1:0]};
      end
      OP_EMIT_LIGHT: out_data_q <= {lit_q[2], lit_q[1], lit_q[0]};
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign stat_o.sqrt_busy = (sb_q != '0);
  assign stat_o.div_busy  = (dcnt_q != '0);
  assign stat_o.light     = light_q;
  assign stat_o.shadowed  = shadowed_q;
  assign stat_o.last      = last_q;
  assign stat_o.wd_zero   = (wd_q == '0);
  assign stat_o.e_zero    = (e_q == '0);
  assign stat_o.cnt_zero  = (count_q == '0);
  assign stat_o.out_full  = out_valid_q;

endmodule

### rtl/core/phong_shading_accumulator_top.sv
// a light sample is only decoded, and with the last mark it emits the light color;
// a shadowed sample skips the shading; a lit sample runs the bit-serial square root
// (22 steps per vector) and the restoring divider (15 steps per vector component)
// and, unless n.l <= 0, the power loop once per bit of shininess; a last sample
// that is no light hit adds six 24-step divisions by a nonzero sample count
// one sample in flight at a time; reset is asynchronous and active low
// ---------------------------------------------------------------------------
// phong_shading_accumulator_top
// per-hit phong shading over a run of light samples
// ---------------------------------------------------------------------------
module phong_shading_accumulator_top import psa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // hit_position, surface_normal, view_origin, light_position,
  // diffuse_color, specular_color, shininess, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // shadowed, hits_light
  input  logic [1:0]            s_axis_tuser,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // red, green, blue
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [COL_W-1:0]      cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  psa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  psa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .stat_o      (stat)
  );

endmodule

### rtl/core/psa_checker.sv
// ---------------------------------------------------------------------------
// psa_checker
// port level checks of the phong shading accumulator
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psa_checker import psa_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [1:0]            s_axis_tuser,
  input logic                  s_axis_tlast,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  cfg_we_i,
  input logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input logic [COL_W-1:0]      cfg_data_i
);

  `PSA_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `PSA_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  `PSA_ASSERT(a_single_word, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  `PSA_ASSERT(a_no_early_result, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))

endmodule

bind phong_shading_accumulator_top psa_checker u_psa_checker (.*);
